@@ rtl/ldcc_pkg.sv @@
`default_nettype none
package ldcc_pkg;

   localparam int MAP_DEPTH      = 4096;
   localparam int COUNT_BITS     = 32;
   localparam int ROW_BITS       = 32;
   localparam int MAP_ROWS       = MAP_DEPTH / ROW_BITS;
   localparam int MAP_ADDR_BITS  = $clog2(MAP_DEPTH);
   localparam int BIT_IDX_BITS   = $clog2(ROW_BITS);
   localparam int ROW_IDX_BITS   = MAP_ADDR_BITS - BIT_IDX_BITS;

   localparam int GID_BITS       = 32;
   localparam int REL_BITS       = 12;
   localparam int TAG_BITS       = 16;
   localparam int SIZE_BITS      = 13;
   localparam int OUT_COUNT_BITS = 32;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 32;
   localparam int MODE_BITS      = 2;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   localparam logic [CSR_INDEX_BITS-1:0] REG_POSITIVE_LIMIT = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LABEL_MODE     = 1'd1;

   localparam logic [MODE_BITS-1:0] MODE_THRESHOLD = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_ALL_POS   = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_ALL_NEG   = 2'd2;

   typedef struct packed {
      logic                    pos;
      logic                    oor;
      logic                    clr_counts;
      logic                    clear_pos;
      logic                    clear_neg;
      logic [ROW_IDX_BITS-1:0] row;
      logic [BIT_IDX_BITS-1:0] bit_idx;
   } work_item_type;

endpackage
`default_nettype wire

@@ rtl/ldcc_if.sv @@
`default_nettype none
interface ldcc_req_if;
   logic                           valid;
   logic                           ready;
   logic [ldcc_pkg::GID_BITS-1:0]  global_tuple_id;
   logic [ldcc_pkg::REL_BITS-1:0]  relative_id;
   logic [ldcc_pkg::TAG_BITS-1:0]  partition_tag;
   logic [ldcc_pkg::SIZE_BITS-1:0] partition_size;
   logic                           clear_counts;

   modport source (output valid, global_tuple_id, relative_id, partition_tag,
                   partition_size, clear_counts, input ready);
   modport sink (input valid, global_tuple_id, relative_id, partition_tag,
                 partition_size, clear_counts, output ready);
endinterface

interface ldcc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                is_positive;
   logic                                newly_covered;
   logic                                out_of_range;
   logic [ldcc_pkg::OUT_COUNT_BITS-1:0] bound_positive;
   logic [ldcc_pkg::OUT_COUNT_BITS-1:0] bound_negative;
   logic [ldcc_pkg::OUT_COUNT_BITS-1:0] covered_positive;
   logic [ldcc_pkg::OUT_COUNT_BITS-1:0] covered_negative;

   modport source (output valid, is_positive, newly_covered, out_of_range,
                   bound_positive, bound_negative, covered_positive,
                   covered_negative, input ready);
   modport sink (input valid, is_positive, newly_covered, out_of_range,
                 bound_positive, bound_negative, covered_positive,
                 covered_negative, output ready);
endinterface

interface ldcc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [ldcc_pkg::CSR_INDEX_BITS-1:0] index;
   logic [ldcc_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/labeled_distinct_coverage_counter.sv @@
// labeled distinct coverage counter
// req_bus takes one joined tuple word per cycle while ready; rsp_bus returns
// one word per tuple, in order, with the label, the newly-covered and
// out-of-range flags and the four saturating counters as they stand after
// that tuple. csr_bus writes positive_limit (index 0) and label_mode
// (index 1); it is always ready; the user must write it only while the block
// is idle, which the block itself does not enforce.
// an accepted tuple passes the queue, the row-read stage and the result register.
// throughput: one tuple per cycle while the tag stays the same and rsp_bus
// is ready, set by the read-modify-write of one bitmap row per cycle.
// a new partition tag starts a clearing pass over all MAP_ROWS rows (128),
// one bitmap row per cycle, before that tuple is processed; the front keeps
// taking tuples into a 4-entry queue.
// reset: all counters, the partition tag and the registers go to zero and
// both bitmaps are swept clean row by row; tuples wait in the queue.
// rsp_bus stall: the result register holds, the back end stops, the queue
// fills and req_bus.ready drops when it is full.
`default_nettype none
module labeled_distinct_coverage_counter (
   input  wire          clock,
   input  wire          reset,
   ldcc_req_if.sink     req_bus,
   ldcc_rsp_if.source   rsp_bus,
   ldcc_csr_if.sink     csr_bus
);

   logic                    push_valid;
   ldcc_pkg::work_item_type push_item;
   logic                    queue_full;
   logic                    pop;
   logic                    head_valid;
   ldcc_pkg::work_item_type head_item;

   ldcc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   ldcc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   ldcc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule
`default_nettype wire

@@ rtl/ldcc_front.sv @@
`default_nettype none
module ldcc_front (
   input  wire                    clock,
   input  wire                    reset,
   ldcc_req_if.sink               req_bus,
   ldcc_csr_if.sink               csr_bus,
   input  wire                    queue_full,
   output logic                   push_valid,
   output ldcc_pkg::work_item_type push_item
);

   logic [ldcc_pkg::GID_BITS-1:0]  limit_ff, limit_in;
   logic [ldcc_pkg::MODE_BITS-1:0] mode_ff, mode_in;
   logic [ldcc_pkg::TAG_BITS-1:0]  last_tag_ff, last_tag_in;
   logic                           known_ff, known_in;

   logic                             pos;
   logic                             oor;
   logic                             change;
   logic [ldcc_pkg::MAP_ADDR_BITS-1:0] addr;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = !queue_full;
   assign push_valid    = req_bus.valid && !queue_full;

   always_comb begin
      unique case (mode_ff)
         ldcc_pkg::MODE_ALL_POS: pos = 1'b1;
         ldcc_pkg::MODE_ALL_NEG: pos = 1'b0;
         default:                pos = req_bus.global_tuple_id < limit_ff;
      endcase
      change = !known_ff || (req_bus.partition_tag != last_tag_ff);
      // effective size is the smaller of the partition size and the map depth
      oor = (32'(req_bus.relative_id) >= 32'(req_bus.partition_size)) ||
            (32'(req_bus.relative_id) >= 32'(ldcc_pkg::MAP_DEPTH));
      addr = ldcc_pkg::MAP_ADDR_BITS'(req_bus.relative_id);

      push_item.pos        = pos;
      push_item.oor        = oor;
      push_item.clr_counts = req_bus.clear_counts;
      push_item.clear_pos  = change && (mode_ff != ldcc_pkg::MODE_ALL_NEG);
      push_item.clear_neg  = change && (mode_ff != ldcc_pkg::MODE_ALL_POS);
      push_item.row        = addr[ldcc_pkg::MAP_ADDR_BITS-1:ldcc_pkg::BIT_IDX_BITS];
      push_item.bit_idx    = addr[ldcc_pkg::BIT_IDX_BITS-1:0];
   end

   always_comb begin
      limit_in    = limit_ff;
      mode_in     = mode_ff;
      last_tag_in = last_tag_ff;
      known_in    = known_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            ldcc_pkg::REG_POSITIVE_LIMIT: limit_in = csr_bus.data;
            ldcc_pkg::REG_LABEL_MODE:     mode_in  = csr_bus.data[ldcc_pkg::MODE_BITS-1:0];
            default: ;
         endcase
      end
      if (push_valid) begin
         last_tag_in = req_bus.partition_tag;
         known_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= '0;
         mode_ff     <= ldcc_pkg::MODE_THRESHOLD;
         last_tag_ff <= '0;
         known_ff    <= 1'b0;
      end else begin
         limit_ff    <= limit_in;
         mode_ff     <= mode_in;
         last_tag_ff <= last_tag_in;
         known_ff    <= known_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/ldcc_queue.sv @@
`default_nettype none
module ldcc_queue (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push_valid,
   input  ldcc_pkg::work_item_type push_item,
   output logic                    full,
   input  wire                     pop,
   output logic                    head_valid,
   output ldcc_pkg::work_item_type head_item
);

   ldcc_pkg::work_item_type entry_ff [ldcc_pkg::QUEUE_DEPTH];

   logic [ldcc_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ldcc_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ldcc_pkg::QUEUE_PTR_BITS:0]   count_ff, count_in;

   assign full       = count_ff == (ldcc_pkg::QUEUE_PTR_BITS+1)'(ldcc_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

@@ rtl/ldcc_back.sv @@
`default_nettype none
module ldcc_back (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     head_valid,
   input  ldcc_pkg::work_item_type head_item,
   output logic                    pop,
   ldcc_rsp_if.source              rsp_bus
);

   typedef enum logic [1:0] {
      BK_CLEAR = 2'b01,
      BK_RUN   = 2'b10
   } back_state_type;

   typedef logic [ldcc_pkg::ROW_BITS-1:0]   row_type;
   typedef logic [ldcc_pkg::COUNT_BITS-1:0] count_type;

   row_type pos_map_mem [ldcc_pkg::MAP_ROWS];
   row_type neg_map_mem [ldcc_pkg::MAP_ROWS];

   back_state_type                      state_ff, state_in;
   logic [ldcc_pkg::ROW_IDX_BITS-1:0]   clr_row_ff, clr_row_in;
   logic                                clr_pos_ff, clr_pos_in;
   logic                                clr_neg_ff, clr_neg_in;
   logic                                item_pass_ff, item_pass_in;
   logic                                done_ff, done_in;

   logic                                s2_valid_ff, s2_valid_in;
   ldcc_pkg::work_item_type             s2_item_ff;
   row_type                             pos_rd_ff, neg_rd_ff;
   logic                                byp_valid_ff, byp_valid_in;
   logic                                byp_pos_ff;
   logic [ldcc_pkg::ROW_IDX_BITS-1:0]   byp_row_ff;
   row_type                             byp_data_ff;

   count_type bpos_ff, bpos_in, bneg_ff, bneg_in;
   count_type cpos_ff, cpos_in, cneg_ff, cneg_in;
   count_type bpos_base, bneg_base, cpos_base, cneg_base;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_pos_ff, rsp_fresh_ff, rsp_oor_ff;

   logic    rsp_free;
   logic    s2_fire;
   logic    s2_write;
   logic    needs_clear;
   logic    start_clear;
   logic    issue;
   logic    in_clear;
   row_type old_row;
   row_type new_row;
   logic    fresh;
   logic    pos_we;
   logic    neg_we;
   logic [ldcc_pkg::ROW_IDX_BITS-1:0] wr_row;
   row_type wr_data;

   function automatic count_type sat_inc(input count_type v);
      sat_inc = (v == '1) ? v : v + 1'b1;
   endfunction

   assign in_clear    = state_ff == BK_CLEAR;
   assign rsp_free    = !rsp_valid_ff || rsp_bus.ready;
   assign s2_fire     = s2_valid_ff && rsp_free;
   assign s2_write    = s2_fire && !s2_item_ff.oor;
   assign needs_clear = head_valid && (head_item.clear_pos || head_item.clear_neg) && !done_ff;
   assign start_clear = (state_ff == BK_RUN) && needs_clear && !s2_valid_ff;
   assign issue       = (state_ff == BK_RUN) && head_valid && !needs_clear &&
                        (!s2_valid_ff || s2_fire);
   assign pop         = issue;

   // the write at the read edge is missed by the registered read data
   always_comb begin
      if (byp_valid_ff && (byp_pos_ff == s2_item_ff.pos) && (byp_row_ff == s2_item_ff.row)) begin
         old_row = byp_data_ff;
      end else begin
         old_row = s2_item_ff.pos ? pos_rd_ff : neg_rd_ff;
      end
      fresh   = !s2_item_ff.oor && !old_row[s2_item_ff.bit_idx];
      new_row = old_row | (row_type'(1) << s2_item_ff.bit_idx);
   end

   always_comb begin
      bpos_base = s2_item_ff.clr_counts ? '0 : bpos_ff;
      bneg_base = s2_item_ff.clr_counts ? '0 : bneg_ff;
      cpos_base = s2_item_ff.clr_counts ? '0 : cpos_ff;
      cneg_base = s2_item_ff.clr_counts ? '0 : cneg_ff;
      bpos_in   = bpos_base;
      bneg_in   = bneg_base;
      cpos_in   = cpos_base;
      cneg_in   = cneg_base;
      if (!s2_item_ff.oor) begin
         if (s2_item_ff.pos) begin
            bpos_in = sat_inc(bpos_base);
            if (fresh) begin
               cpos_in = sat_inc(cpos_base);
            end
         end else begin
            bneg_in = sat_inc(bneg_base);
            if (fresh) begin
               cneg_in = sat_inc(cneg_base);
            end
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_row_in   = clr_row_ff;
      clr_pos_in   = clr_pos_ff;
      clr_neg_in   = clr_neg_ff;
      item_pass_in = item_pass_ff;
      done_in      = done_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            clr_row_in = clr_row_ff + 1'b1;
            if (clr_row_ff == ldcc_pkg::ROW_IDX_BITS'(ldcc_pkg::MAP_ROWS - 1)) begin
               state_in = BK_RUN;
               done_in  = item_pass_ff;
            end
         end
         BK_RUN: begin
            if (start_clear) begin
               state_in     = BK_CLEAR;
               clr_row_in   = '0;
               clr_pos_in   = head_item.clear_pos;
               clr_neg_in   = head_item.clear_neg;
               item_pass_in = 1'b1;
            end else if (issue) begin
               done_in = 1'b0;
            end
         end
         default: state_in = BK_CLEAR;
      endcase
   end

   always_comb begin
      s2_valid_in  = issue ? 1'b1 : (s2_fire ? 1'b0 : s2_valid_ff);
      byp_valid_in = issue ? s2_write : byp_valid_ff;
      rsp_valid_in = s2_fire ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_row_ff   <= '0;
         clr_pos_ff   <= 1'b1;
         clr_neg_ff   <= 1'b1;
         item_pass_ff <= 1'b0;
         done_ff      <= 1'b0;
         s2_valid_ff  <= 1'b0;
         byp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bpos_ff      <= '0;
         bneg_ff      <= '0;
         cpos_ff      <= '0;
         cneg_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         clr_row_ff   <= clr_row_in;
         clr_pos_ff   <= clr_pos_in;
         clr_neg_ff   <= clr_neg_in;
         item_pass_ff <= item_pass_in;
         done_ff      <= done_in;
         s2_valid_ff  <= s2_valid_in;
         byp_valid_ff <= byp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s2_fire) begin
            bpos_ff <= bpos_in;
            bneg_ff <= bneg_in;
            cpos_ff <= cpos_in;
            cneg_ff <= cneg_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s2_item_ff  <= head_item;
         byp_pos_ff  <= s2_item_ff.pos;
         byp_row_ff  <= s2_item_ff.row;
         byp_data_ff <= new_row;
      end
      if (s2_fire) begin
         rsp_pos_ff   <= s2_item_ff.pos;
         rsp_fresh_ff <= fresh;
         rsp_oor_ff   <= s2_item_ff.oor;
      end
   end

   // bitmap write port: clearing pass or test-and-set
   always_comb begin
      wr_row  = in_clear ? clr_row_ff : s2_item_ff.row;
      wr_data = in_clear ? '0 : new_row;
      pos_we  = in_clear ? clr_pos_ff : (s2_write && s2_item_ff.pos);
      neg_we  = in_clear ? clr_neg_ff : (s2_write && !s2_item_ff.pos);
   end

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_map_mem[wr_row] <= wr_data;
      end
      if (issue) begin
         pos_rd_ff <= pos_map_mem[head_item.row];
      end
   end

   always_ff @(posedge clock) begin
      if (neg_we) begin
         neg_map_mem[wr_row] <= wr_data;
      end
      if (issue) begin
         neg_rd_ff <= neg_map_mem[head_item.row];
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.is_positive      = rsp_pos_ff;
   assign rsp_bus.newly_covered    = rsp_fresh_ff;
   assign rsp_bus.out_of_range     = rsp_oor_ff;
   assign rsp_bus.bound_positive   = ldcc_pkg::OUT_COUNT_BITS'(bpos_ff);
   assign rsp_bus.bound_negative   = ldcc_pkg::OUT_COUNT_BITS'(bneg_ff);
   assign rsp_bus.covered_positive = ldcc_pkg::OUT_COUNT_BITS'(cpos_ff);
   assign rsp_bus.covered_negative = ldcc_pkg::OUT_COUNT_BITS'(cneg_ff);

endmodule
`default_nettype wire
